/* rtl/iept_pkg.sv */
// Package: shared constants and types for the input event pointer tracker.
package iept_pkg;

    localparam int RawW  = 32;
    localparam int DispW = 15;
    localparam int KeyW  = 3;
    localparam int CfgIdxW = 3;

    localparam logic [15:0] EVT_KEY = 16'd1;
    localparam logic [15:0] EVT_REL = 16'd2;
    localparam logic [15:0] EVT_ABS = 16'd3;

    localparam logic [15:0] CODE_AXIS_X    = 16'h0000;
    localparam logic [15:0] CODE_AXIS_Y    = 16'h0001;
    localparam logic [15:0] CODE_SLOT      = 16'h002F;
    localparam logic [15:0] CODE_MT_X      = 16'h0035;
    localparam logic [15:0] CODE_MT_Y      = 16'h0036;
    localparam logic [15:0] CODE_TRACK     = 16'h0039;
    localparam logic [15:0] CODE_BTN_LEFT  = 16'h0110;
    localparam logic [15:0] CODE_BTN_TOUCH = 16'h014A;

    localparam logic [1:0] MODE_POINTER = 2'd0;
    localparam logic [1:0] MODE_KEYPAD  = 2'd1;

    localparam logic [CfgIdxW-1:0] REG_DEVICE_MODE = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SWAP_AXES   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_X_MIN       = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_X_MAX       = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_Y_MIN       = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_Y_MAX       = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_DISP_W      = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_DISP_H      = 3'd7;

    localparam logic KIND_POINTER = 1'b0;
    localparam logic KIND_KEYPAD  = 1'b1;

    typedef struct packed {
        logic             op;
        logic [15:0]      event_type;
        logic [15:0]      event_code;
        logic [RawW-1:0]  event_value;
    } in_item_t;

    typedef struct packed {
        logic             report_kind;
        logic [DispW-1:0] point_x;
        logic [DispW-1:0] point_y;
        logic             pressed;
        logic [KeyW-1:0]  key_code;
    } out_item_t;

    typedef struct packed {
        logic [CfgIdxW-1:0] index;
        logic [31:0]        data;
    } cfg_item_t;

    // Start, busy and done flags of one axis scaling job
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } axis_ctl_t;

    function automatic logic [KeyW-1:0] key_map(input logic [15:0] code);
        logic [KeyW-1:0] k;
        unique case (code)
            16'd14:  k = 3'd1;
            16'd28:  k = 3'd2;
            16'd103: k = 3'd3;
            16'd105: k = 3'd4;
            16'd106: k = 3'd5;
            16'd108: k = 3'd6;
            default: k = 3'd0;
        endcase
        return k;
    endfunction

endpackage

/* rtl/iept_if.sv */
// Interfaces: valid/ready channels for items and configuration writes.
interface iept_in_if;
    logic               valid;
    logic               ready;
    iept_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface iept_out_if;
    logic                valid;
    logic                ready;
    iept_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface iept_cfg_if;
    logic                valid;
    logic                ready;
    iept_pkg::cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/input_event_pointer_tracker.sv */
// Top level: event decode, pointer state, poll scaling and report output.
//
//  channel | dir | payload                                   | accept
//  in_ch   | in  | op, event_type, event_code, event_value     | valid && ready
//  out_ch  | out | report_kind, point_x, point_y, pressed, key | valid && ready
//  cfg_ch  | in  | index (3 bits), data (32 bits)              | valid && ready
//
// An event is taken when the block is idle with no report pending; a report holds input off until it is taken.
// A pointer poll runs both axes together through bit-serial scalers: multiply, divide
// and clamp steps, then the report is registered; an unscaled poll goes straight to the clamp.
// No new item is accepted during a poll or while a report waits for the receiver,
// so receiver stalls hold off the input.
// Reset is asynchronous, active low, and clears state and configuration.
module input_event_pointer_tracker (
    input logic clk,
    input logic rst_n,
    iept_in_if.sink    in_ch,
    iept_out_if.source out_ch,
    iept_cfg_if.sink   cfg_ch
);
    typedef enum logic [1:0] {S_IDLE, S_POLL, S_WAIT} state_t;

    state_t state_reg;
    logic [1:0]  mode_reg;
    logic        swap_reg;
    logic [31:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic [iept_pkg::DispW-1:0] disp_w_reg, disp_h_reg;
    logic [31:0] raw_x_reg, raw_y_reg;
    logic        other_reg, press_reg;
    logic [iept_pkg::KeyW-1:0] key_reg;
    logic        ovalid_reg;
    iept_pkg::out_item_t odata_reg;

    iept_pkg::in_item_t it;
    logic acc, start, to_y;
    iept_pkg::axis_ctl_t cx, cy;
    logic [iept_pkg::DispW-1:0] px, py;
    logic [iept_pkg::KeyW-1:0] km;

    assign it    = in_ch.data;
    assign in_ch.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign acc   = in_ch.valid && in_ch.ready;
    assign start = acc && it.op && (mode_reg == iept_pkg::MODE_POINTER);
    assign cfg_ch.ready = 1'b1;
    assign km = iept_pkg::key_map(it.event_code);

    // Target axis after optional swap
    assign to_y = ((it.event_code == iept_pkg::CODE_AXIS_Y) ||
                   (it.event_code == iept_pkg::CODE_MT_Y)) ^ swap_reg;

    iept_axis u_ax (
        .clk(clk), .rst_n(rst_n), .start(start), .raw(raw_x_reg),
        .mn(x_min_reg), .mx(x_max_reg), .size(disp_w_reg),
        .scale(x_max_reg != '0), .ctl(cx), .result(px)
    );
    iept_axis u_ay (
        .clk(clk), .rst_n(rst_n), .start(start), .raw(raw_y_reg),
        .mn(y_min_reg), .mx(y_max_reg), .size(disp_h_reg),
        .scale(x_max_reg != '0), .ctl(cy), .result(py)
    );

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0; swap_reg <= 1'b0;
            x_min_reg <= '0; x_max_reg <= '0; y_min_reg <= '0; y_max_reg <= '0;
            disp_w_reg <= 15'd800; disp_h_reg <= 15'd480;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.data.index)
                iept_pkg::REG_DEVICE_MODE: mode_reg <= cfg_ch.data.data[1:0];
                iept_pkg::REG_SWAP_AXES:   swap_reg <= cfg_ch.data.data[0];
                iept_pkg::REG_X_MIN:       x_min_reg <= cfg_ch.data.data;
                iept_pkg::REG_X_MAX:       x_max_reg <= cfg_ch.data.data;
                iept_pkg::REG_Y_MIN:       y_min_reg <= cfg_ch.data.data;
                iept_pkg::REG_Y_MAX:       y_max_reg <= cfg_ch.data.data;
                iept_pkg::REG_DISP_W:      disp_w_reg <= cfg_ch.data.data[14:0];
                iept_pkg::REG_DISP_H:      disp_h_reg <= cfg_ch.data.data[14:0];
                default: ;
            endcase
        end
    end

    // Decode items, advance pointer state and hold the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            raw_x_reg <= '0; raw_y_reg <= '0;
            other_reg <= 1'b0; press_reg <= 1'b0; key_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && out_ch.ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (acc && it.op)
                    begin
                        if (mode_reg == iept_pkg::MODE_KEYPAD)
                        begin
                            odata_reg <= '{iept_pkg::KIND_KEYPAD, '0, '0, press_reg, key_reg};
                            ovalid_reg <= 1'b1;
                        end
                        else if (mode_reg == iept_pkg::MODE_POINTER)
                            state_reg <= S_POLL;
                    end
                    else if (acc)
                    begin
                        priority if (it.event_type == iept_pkg::EVT_REL)
                        begin
                            if (it.event_code == iept_pkg::CODE_AXIS_X ||
                                it.event_code == iept_pkg::CODE_AXIS_Y)
                            begin
                                if (to_y) raw_y_reg <= raw_y_reg + it.event_value;
                                else      raw_x_reg <= raw_x_reg + it.event_value;
                            end
                        end
                        else if (it.event_type == iept_pkg::EVT_ABS)
                        begin
                            priority if (it.event_code == iept_pkg::CODE_SLOT)
                                other_reg <= (it.event_value != '0);
                            else if (other_reg)
                                ;
                            else if (it.event_code == iept_pkg::CODE_AXIS_X ||
                                     it.event_code == iept_pkg::CODE_MT_X ||
                                     it.event_code == iept_pkg::CODE_AXIS_Y ||
                                     it.event_code == iept_pkg::CODE_MT_Y)
                            begin
                                if (to_y) raw_y_reg <= it.event_value;
                                else      raw_x_reg <= it.event_value;
                            end
                            else if (it.event_code == iept_pkg::CODE_TRACK)
                                press_reg <= (it.event_value != '1);
                            else
                                ;
                        end
                        else if (it.event_type == iept_pkg::EVT_KEY)
                        begin
                            priority if (it.event_code == iept_pkg::CODE_BTN_LEFT ||
                                         it.event_code == iept_pkg::CODE_BTN_TOUCH)
                            begin
                                if (it.event_value == 32'd0)      press_reg <= 1'b0;
                                else if (it.event_value == 32'd1) press_reg <= 1'b1;
                            end
                            else if (mode_reg == iept_pkg::MODE_KEYPAD)
                            begin
                                press_reg <= (it.event_value != '0);
                                key_reg   <= km;
                                odata_reg <= '{iept_pkg::KIND_KEYPAD, '0, '0,
                                               (it.event_value != '0), km};
                                ovalid_reg <= 1'b1;
                            end
                            else
                                ;
                        end
                        else
                            ;
                    end
                end
                S_POLL:
                    state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (!cx.busy && !cy.busy)
                    begin
                        odata_reg <= '{iept_pkg::KIND_POINTER, px, py, press_reg, '0};
                        ovalid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = odata_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ch.ready)
        else $error("item accepted during poll");
    a_axes_together: assert property (@(posedge clk) disable iff (!rst_n)
        cx.start |-> cy.start)
        else $error("axis scalers started apart");
    a_poll_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT && !cx.busy && !cy.busy) |=> ovalid_reg)
        else $error("poll finished without result");
endmodule

/* rtl/iept_axis.sv */
// Bit-serial axis scaler: (raw-min)*size/(max-min) or raw, then clamp.
module iept_axis (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [iept_pkg::RawW-1:0]  raw,
    input  logic [iept_pkg::RawW-1:0]  mn,
    input  logic [iept_pkg::RawW-1:0]  mx,
    input  logic [iept_pkg::DispW-1:0] size,
    input  logic                       scale,
    output iept_pkg::axis_ctl_t        ctl,
    output logic [iept_pkg::DispW-1:0] result
);
    // Numerator magnitude up to 33+15 bits
    localparam int NumW = iept_pkg::RawW + 1 + iept_pkg::DispW;
    localparam int DenW = iept_pkg::RawW + 1;
    localparam int CntW = $clog2(NumW + 1);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_CLAMP} state_t;

    state_t              state_reg;
    logic [CntW-1:0]     cnt_reg;
    logic [NumW-1:0]     acc_reg;      // product, then quotient
    logic [DenW-1:0]     mcand_reg;    // |raw - min|
    logic [iept_pkg::DispW-1:0] mplier_reg;
    logic [DenW-1:0]     den_reg;      // |max - min|
    logic [DenW:0]       rem_reg;
    logic                neg_reg;
    logic                pass_reg;
    logic signed [DenW-1:0] rawv_reg;
    logic [iept_pkg::DispW-1:0] res_reg;
    logic                done_reg;

    logic signed [DenW-1:0] r_s, lo_s, hi_s, dn_s, dd_s;
    logic [DenW:0]       rem_shift;
    logic [DenW:0]       rem_sub;
    logic [NumW-1:0]     add_val;
    logic signed [NumW:0] v_s;
    logic                ge;

    assign r_s  = DenW'(signed'(raw));
    assign lo_s = DenW'(signed'(mn));
    assign hi_s = DenW'(signed'(mx));
    assign dn_s = r_s - lo_s;
    assign dd_s = hi_s - lo_s;

    // One multiplier bit per cycle: shift-add from the top bit
    assign add_val = mplier_reg[iept_pkg::DispW-1] ? NumW'(mcand_reg) : '0;
    // One quotient bit per cycle: restoring division
    assign rem_shift = {rem_reg[DenW-1:0], acc_reg[NumW-1]};
    assign rem_sub   = rem_shift - {1'b0, den_reg};
    assign ge        = !rem_sub[DenW];

    always_comb
    begin
        if (pass_reg)
            v_s = (NumW + 1)'(rawv_reg);
        else if (neg_reg)
            v_s = -signed'({1'b0, acc_reg});
        else
            v_s = signed'({1'b0, acc_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        rawv_reg   <= r_s;
                        pass_reg   <= !(scale && (hi_s != lo_s));
                        neg_reg    <= dn_s[DenW-1] ^ dd_s[DenW-1];
                        mcand_reg  <= dn_s[DenW-1] ? DenW'(-dn_s) : DenW'(dn_s);
                        den_reg    <= dd_s[DenW-1] ? DenW'(-dd_s) : DenW'(dd_s);
                        mplier_reg <= size;
                        acc_reg    <= '0;
                        rem_reg    <= '0;
                        cnt_reg    <= CntW'(iept_pkg::DispW);
                        state_reg  <= (scale && (hi_s != lo_s)) ? S_MUL : S_CLAMP;
                    end
                end
                S_MUL:
                begin
                    acc_reg    <= {acc_reg[NumW-2:0], 1'b0} + add_val;
                    mplier_reg <= {mplier_reg[iept_pkg::DispW-2:0], 1'b0};
                    cnt_reg    <= cnt_reg - 1'b1;
                    if (cnt_reg == CntW'(1))
                    begin
                        cnt_reg   <= CntW'(NumW);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= ge ? rem_sub : rem_shift;
                    acc_reg <= {acc_reg[NumW-2:0], ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CntW'(1))
                        state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    if (size == '0 || v_s < 0)
                        res_reg <= '0;
                    else if (v_s >= signed'((NumW + 1)'(size)))
                        res_reg <= size - 1'b1;
                    else
                        res_reg <= v_s[iept_pkg::DispW-1:0];
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = (state_reg != S_IDLE);
    assign ctl.done  = done_reg;
    assign result    = res_reg;

    a_done_after_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == S_CLAMP)
        else $error("done without clamp step");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |=> (state_reg == S_DIV || state_reg == S_CLAMP))
        else $error("divide left early");
    a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && size != '0 |-> res_reg < size)
        else $error("clamp out of range");
endmodule

/* tb/sv/tb_input_event_pointer_tracker.sv */
// Testbench: checks the event pointer tracker against a local model of its behaviour.
`timescale 1ns / 100ps

module tb_input_event_pointer_tracker;

    logic clk;
    logic rst_n;

    iept_in_if  in_ch ();
    iept_out_if out_ch ();
    iept_cfg_if cfg_ch ();

    input_event_pointer_tracker u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    // Idling profiles
    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_t;

    // Directed row: expected result typed in only where it is obvious
    typedef struct {
        iept_pkg::in_item_t  ev;
        bit                  typed;
        iept_pkg::out_item_t res;
    } stim_row_t;

    // Model copy of configuration and pointer state
    logic [1:0]                 m_mode;
    logic                       m_swap;
    logic [31:0]                m_xmin, m_xmax, m_ymin, m_ymax;
    logic [iept_pkg::DispW-1:0] m_dw, m_dh;
    logic [31:0]                m_raw_x, m_raw_y;
    logic                       m_other_slot;
    logic                       m_press;
    logic [iept_pkg::KeyW-1:0]  m_last_key;

    iept_pkg::out_item_t report_q[$];
    idle_mode_t idle_mode;
    int         send_gap_pct;
    int         mismatches;
    bit         failed;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Limit of the run
    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [iept_pkg::KeyW-1:0] keypad_code(input logic [15:0] code);
        case (code)
            16'd14:  return 3'd1;
            16'd28:  return 3'd2;
            16'd103: return 3'd3;
            16'd105: return 3'd4;
            16'd106: return 3'd5;
            16'd108: return 3'd6;
            default: return 3'd0;
        endcase
    endfunction

    // Scale and clamp one axis
    function automatic logic [iept_pkg::DispW-1:0] scale_axis(input logic [31:0] raw,
            input logic [31:0] lo, input logic [31:0] hi,
            input logic [iept_pkg::DispW-1:0] size, input bit scale);
        longint r, l, h, v;
        r = longint'($signed(raw));
        l = longint'($signed(lo));
        h = longint'($signed(hi));
        v = r;
        if (scale && h != l)
            v = ((r - l) * longint'(size)) / (h - l);
        if (v < 0)
            v = 0;
        if (size == 0)
            return '0;
        if (v >= longint'(size))
            v = longint'(size) - 1;
        return v[iept_pkg::DispW-1:0];
    endfunction

    function automatic void move_axis(input bit is_y, input logic [31:0] val, input bit add);
        if (is_y != m_swap)
            m_raw_y = add ? m_raw_y + val : val;
        else
            m_raw_x = add ? m_raw_x + val : val;
    endfunction

    function automatic void reset_tracker();
        m_mode = iept_pkg::MODE_POINTER; m_swap = 0;
        m_xmin = 0; m_xmax = 0; m_ymin = 0; m_ymax = 0;
        m_dw = 800; m_dh = 480;
        m_raw_x = 0; m_raw_y = 0;
        m_other_slot = 0; m_press = 0; m_last_key = 0;
    endfunction

    function automatic void apply_register(input logic [iept_pkg::CfgIdxW-1:0] idx,
            input logic [31:0] d);
        case (idx)
            iept_pkg::REG_DEVICE_MODE: m_mode = d[1:0];
            iept_pkg::REG_SWAP_AXES:   m_swap = d[0];
            iept_pkg::REG_X_MIN:       m_xmin = d;
            iept_pkg::REG_X_MAX:       m_xmax = d;
            iept_pkg::REG_Y_MIN:       m_ymin = d;
            iept_pkg::REG_Y_MAX:       m_ymax = d;
            iept_pkg::REG_DISP_W:      m_dw = d[iept_pkg::DispW-1:0];
            iept_pkg::REG_DISP_H:      m_dh = d[iept_pkg::DispW-1:0];
            default: ;
        endcase
    endfunction

    // Advance the tracker by one item; returns 1 with a report if one is due
    function automatic bit track_event(input iept_pkg::in_item_t ev,
            output iept_pkg::out_item_t rep);
        rep = '0;
        if (ev.op)
        begin
            if (m_mode == iept_pkg::MODE_KEYPAD)
            begin
                rep.report_kind = iept_pkg::KIND_KEYPAD;
                rep.pressed = m_press;
                rep.key_code = m_last_key;
                return 1;
            end
            if (m_mode != iept_pkg::MODE_POINTER)
                return 0;
            rep.report_kind = iept_pkg::KIND_POINTER;
            rep.point_x = scale_axis(m_raw_x, m_xmin, m_xmax, m_dw, m_xmax != 0);
            rep.point_y = scale_axis(m_raw_y, m_ymin, m_ymax, m_dh, m_xmax != 0);
            rep.pressed = m_press;
            return 1;
        end
        if (ev.event_type == iept_pkg::EVT_REL)
        begin
            if (ev.event_code == iept_pkg::CODE_AXIS_X)
                move_axis(0, ev.event_value, 1);
            else if (ev.event_code == iept_pkg::CODE_AXIS_Y)
                move_axis(1, ev.event_value, 1);
        end
        else if (ev.event_type == iept_pkg::EVT_ABS)
        begin
            if (ev.event_code == iept_pkg::CODE_SLOT)
                m_other_slot = (ev.event_value != 0);
            else if (m_other_slot)
                ;
            else if (ev.event_code == iept_pkg::CODE_AXIS_X ||
                     ev.event_code == iept_pkg::CODE_MT_X)
                move_axis(0, ev.event_value, 0);
            else if (ev.event_code == iept_pkg::CODE_AXIS_Y ||
                     ev.event_code == iept_pkg::CODE_MT_Y)
                move_axis(1, ev.event_value, 0);
            else if (ev.event_code == iept_pkg::CODE_TRACK)
                m_press = (ev.event_value != 32'hFFFF_FFFF);
        end
        else if (ev.event_type == iept_pkg::EVT_KEY)
        begin
            if (ev.event_code == iept_pkg::CODE_BTN_LEFT ||
                ev.event_code == iept_pkg::CODE_BTN_TOUCH)
            begin
                if (ev.event_value == 0)
                    m_press = 0;
                else if (ev.event_value == 1)
                    m_press = 1;
            end
            else if (m_mode == iept_pkg::MODE_KEYPAD)
            begin
                m_press = (ev.event_value != 0);
                m_last_key = keypad_code(ev.event_code);
                rep.report_kind = iept_pkg::KIND_KEYPAD;
                rep.pressed = m_press;
                rep.key_code = m_last_key;
                return 1;
            end
        end
        return 0;
    endfunction

    // Receiver: stall at random under the receive idling profiles and check each accepted report
    always @(posedge clk)
    begin
        iept_pkg::out_item_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            if (report_q.size() == 0)
            begin
                failed <= 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report %p", out_ch.data);
            end
            else
            begin
                want = report_q.pop_front();
                if (out_ch.data !== want)
                begin
                    failed <= 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("report mismatch: expected %p, got %p", want, out_ch.data);
                end
            end
        end
        if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH)
            out_ch.ready <= ($urandom_range(99) >= (idle_mode == IDLE_RECV ? 51 : 17));
        else
            out_ch.ready <= 1'b1;
    end

    // Offer one write; valid is dropped by the next item sent
    task automatic write_register(input logic [iept_pkg::CfgIdxW-1:0] idx,
            input logic [31:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, data: d};
        do @(posedge clk); while (!cfg_ch.ready);
        apply_register(idx, d);
    endtask

    // Send one item; the expectation is queued as it is accepted
    task automatic send_event(input iept_pkg::in_item_t ev, input bit typed,
            input iept_pkg::out_item_t res);
        iept_pkg::out_item_t rep;
        bit                  due;
        cfg_ch.valid <= 1'b0;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= ev;
        do @(posedge clk); while (!in_ch.ready);
        due = track_event(ev, rep);
        if (typed && (!due || rep !== res))
        begin
            failed = 1'b1;
            $display("typed row disagrees: expected %p, predicted %p", res, rep);
        end
        if (due)
            report_q.push_back(rep);
    endtask

    // Drop the input, wait for the block to drain, then wait on for silent work
    task automatic drain();
        int n;
        n = 0;
        in_ch.valid <= 1'b0;
        while (report_q.size() != 0 && n < 200000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (100) @(posedge clk);
    endtask

    function automatic iept_pkg::in_item_t mk(input bit op, input logic [15:0] t,
            input logic [15:0] c, input logic [31:0] v);
        iept_pkg::in_item_t e;
        e.op = op; e.event_type = t; e.event_code = c; e.event_value = v;
        return e;
    endfunction

    // Random item, mostly meaningful events
    function automatic iept_pkg::in_item_t rand_event();
        logic [15:0]        codes[10];
        logic [15:0]        keys[8];
        iept_pkg::in_item_t e;
        int                 pick;
        codes = '{iept_pkg::CODE_AXIS_X, iept_pkg::CODE_AXIS_Y, iept_pkg::CODE_SLOT,
                  iept_pkg::CODE_MT_X, iept_pkg::CODE_MT_Y, iept_pkg::CODE_TRACK,
                  iept_pkg::CODE_BTN_LEFT, iept_pkg::CODE_BTN_TOUCH, 16'd14, 16'd108};
        keys = '{16'd14, 16'd28, 16'd103, 16'd105, 16'd106, 16'd108, 16'd30, 16'hFFFF};
        e = mk(0, 16'($urandom), 16'($urandom), $urandom);
        pick = $urandom_range(99);
        if (pick < 25)
            e.op = 1;
        else if (pick < 85)
        begin
            e.event_type = 16'($urandom_range(3, 1));
            e.event_code = codes[$urandom_range(9)];
            if (e.event_type == iept_pkg::EVT_KEY && $urandom_range(1))
                e.event_code = keys[$urandom_range(7)];
            if (e.event_code == iept_pkg::CODE_SLOT)
                e.event_value = ($urandom_range(3) == 0) ? $urandom : 0;
            else if ($urandom_range(3) == 0)
                e.event_value = 32'($signed($urandom_range(4)) - 2);
            else if ($urandom_range(1))
                e.event_value = $urandom_range(4000);
        end
        else if (pick < 92)
            e.event_type = 16'($urandom_range(3, 1));
        return e;
    endfunction

    task automatic random_config(input int variant);
        logic [31:0] mn;
        write_register(iept_pkg::REG_DEVICE_MODE, (variant % 5 == 3) ? 2 + $urandom_range(1)
                                        : ((variant % 5 == 1) ? 1 : 0));
        write_register(iept_pkg::REG_SWAP_AXES, $urandom_range(1));
        mn = (variant % 4 == 0) ? 32'h8000_0000 : 32'($signed($urandom_range(200)) - 100);
        write_register(iept_pkg::REG_X_MIN, mn);
        write_register(iept_pkg::REG_X_MAX, (variant % 4 == 0) ? 32'h7FFF_FFFF
                                   : (variant % 4 == 1 ? 0 : mn + $urandom_range(5000)));
        write_register(iept_pkg::REG_Y_MIN,
                       (variant % 4 == 0) ? 32'h7FFF_FFFF : 32'($urandom_range(50)));
        write_register(iept_pkg::REG_Y_MAX,
                       (variant % 4 == 0) ? 32'h8000_0000 : 32'($urandom_range(4000)));
        write_register(iept_pkg::REG_DISP_W,
                       (variant % 3 == 0) ? 32767 : $urandom_range(2000, 1));
        write_register(iept_pkg::REG_DISP_H,
                       (variant % 3 == 1) ? 1 : $urandom_range(2000, 1));
    endtask

    // Directed table, then random phases under each idling profile
    initial
    begin
        stim_row_t           rows[$];
        iept_pkg::out_item_t none;
        none = '0;
        reset_tracker();
        failed = 0;
        mismatches = 0;
        idle_mode = IDLE_NONE;
        send_gap_pct = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // poll after reset reports origin, released
        rows.push_back('{mk(1, 0, 0, 0), 1,
                         '{iept_pkg::KIND_POINTER, 15'd0, 15'd0, 1'b0, 3'd0}});
        rows.push_back('{mk(0, iept_pkg::EVT_ABS, iept_pkg::CODE_AXIS_X, 32'h7FFF_FFFF),
                         0, none});
        rows.push_back('{mk(0, iept_pkg::EVT_ABS, iept_pkg::CODE_MT_Y, 32'h8000_0000),
                         0, none});
        rows.push_back('{mk(1, 0, 0, 0), 1,
                         '{iept_pkg::KIND_POINTER, 15'd799, 15'd0, 1'b0, 3'd0}});
        rows.push_back('{mk(0, iept_pkg::EVT_REL, iept_pkg::CODE_AXIS_X, 32'd1), 0, none});
        rows.push_back('{mk(0, iept_pkg::EVT_REL, iept_pkg::CODE_AXIS_Y, 32'hFFFF_FFFF),
                         0, none});
        rows.push_back('{mk(0, iept_pkg::EVT_ABS, iept_pkg::CODE_TRACK, 32'd5), 0, none});
        rows.push_back('{mk(1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF), 0, none});
        rows.push_back('{mk(0, iept_pkg::EVT_ABS, iept_pkg::CODE_TRACK, 32'hFFFF_FFFF),
                         0, none});
        rows.push_back('{mk(0, iept_pkg::EVT_KEY, iept_pkg::CODE_BTN_TOUCH, 32'd1), 0, none});
        rows.push_back('{mk(0, iept_pkg::EVT_KEY, iept_pkg::CODE_BTN_LEFT, 32'd7), 0, none});
        rows.push_back('{mk(0, iept_pkg::EVT_ABS, iept_pkg::CODE_SLOT, 32'd1), 0, none});
        rows.push_back('{mk(0, iept_pkg::EVT_ABS, iept_pkg::CODE_MT_X, 32'd100), 0, none});
        rows.push_back('{mk(0, iept_pkg::EVT_ABS, iept_pkg::CODE_TRACK, 32'hFFFF_FFFF),
                         0, none});
        rows.push_back('{mk(0, iept_pkg::EVT_REL, iept_pkg::CODE_AXIS_X, 32'd5), 0, none});
        rows.push_back('{mk(0, iept_pkg::EVT_ABS, iept_pkg::CODE_SLOT, 32'd0), 0, none});
        rows.push_back('{mk(0, iept_pkg::EVT_ABS, iept_pkg::CODE_MT_X, 32'd300), 0, none});
        rows.push_back('{mk(0, 16'hFFFF, iept_pkg::CODE_AXIS_X, 32'd9), 0, none});
        rows.push_back('{mk(0, iept_pkg::EVT_KEY, iept_pkg::CODE_BTN_LEFT, 32'd0), 0, none});
        rows.push_back('{mk(1, 0, 0, 0), 0, none});
        foreach (rows[i])
            send_event(rows[i].ev, rows[i].typed, rows[i].res);
        drain();

        // keypad mode with swapped axes
        write_register(iept_pkg::REG_DEVICE_MODE, iept_pkg::MODE_KEYPAD);
        write_register(iept_pkg::REG_SWAP_AXES, 1);
        send_event(mk(0, iept_pkg::EVT_KEY, 16'd28, 32'd1), 1,
                   '{iept_pkg::KIND_KEYPAD, 15'd0, 15'd0, 1'b1, 3'd2});
        send_event(mk(0, iept_pkg::EVT_KEY, 16'd999, 32'd0), 1,
                   '{iept_pkg::KIND_KEYPAD, 15'd0, 15'd0, 1'b0, 3'd0});
        send_event(mk(1, 0, 0, 0), 1, '{iept_pkg::KIND_KEYPAD, 15'd0, 15'd0, 1'b0, 3'd0});
        send_event(mk(0, iept_pkg::EVT_ABS, iept_pkg::CODE_AXIS_X, 32'd40), 0, none);
        drain();

        // random phases; the sender holds off until drained after each
        for (int ph = 0; ph < 12; ph++)
        begin
            idle_mode = idle_mode_t'(ph % 4);
            send_gap_pct = (idle_mode == IDLE_SEND) ? 51 : (idle_mode == IDLE_BOTH ? 17 : 0);
            random_config(ph);
            if (ph % 4 == 0)
                write_register(iept_pkg::REG_DISP_W, 0);
            repeat (95) send_event(rand_event(), 0, none);
            drain();
        end

        if (report_q.size() != 0)
            failed = 1;
        if (!failed)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
